/* rtl/ogi_pkg.sv */
`default_nettype none

package ogi_pkg;

  // Field and register widths
  localparam int REG_W   = 10;
  localparam int RAD_W   = 3;
  localparam int POS_W   = 9;
  localparam int CELL_W  = 8;
  localparam int INDEX_W = 2;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_RADIUS      = 2'd2;

  // Cell codes
  localparam logic signed [CELL_W-1:0] CELL_HARD = 8'sd100;
  localparam logic signed [CELL_W-1:0] CELL_SOFT = 8'sd99;
  localparam logic signed [CELL_W-1:0] CELL_MARK = 8'sd50;

  typedef logic [REG_W-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic is_obstacle(input logic signed [CELL_W-1:0] v);
    return (v == CELL_HARD) || (v == CELL_SOFT);
  endfunction

endpackage

`default_nettype wire

/* rtl/ogi_ram.sv */
`default_nettype none

module ogi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/occupancy_grid_inflation.sv */
// Channel  | handshake            | word
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | opcode, cell_x, cell_y, write_value
// out      | out_valid / out_ready| inflated_value, out_of_grid
// cfg      | cfg_write            | cfg_index, cfg_data
//
// A write is done as it is accepted. A read inside the grid scans N cells, N being
// the number of cells of the clipped square window, (2R+1)^2 at most: the
// single read port of the grid memory visits one cell per cycle.
// An out-of-grid read skips the scan. Results wait in an output register.
// Reset (rst, synchronous) restores config, state and valid bits; grid stays.
`default_nettype none

module occupancy_grid_inflation #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [ogi_pkg::INDEX_W-1:0]          cfg_index,
  input  wire logic [ogi_pkg::REG_W-1:0]            cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 opcode,
  input  wire logic [ogi_pkg::POS_W-1:0]            cell_x,
  input  wire logic [ogi_pkg::POS_W-1:0]            cell_y,
  input  wire logic signed [ogi_pkg::CELL_W-1:0]    write_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [ogi_pkg::CELL_W-1:0]         inflated_value,
  output logic                                      out_of_grid
);

  import ogi_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int REG_MAX = (1 << REG_W) - 1;
  localparam int RAD_MAX = (1 << RAD_W) - 1;
  localparam coord_t W_CAP = REG_W'((MAX_WIDTH > REG_MAX) ? REG_MAX : MAX_WIDTH);
  localparam coord_t H_CAP = REG_W'((MAX_HEIGHT > REG_MAX) ? REG_MAX : MAX_HEIGHT);
  localparam logic [RAD_W-1:0] R_CAP =
    RAD_W'((MAX_RADIUS > RAD_MAX) ? RAD_MAX : MAX_RADIUS);

  // Configuration registers
  coord_t           grid_width;
  coord_t           grid_height;
  logic [RAD_W-1:0] inflation_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= REG_W'(512);
      grid_height      <= REG_W'(512);
      inflation_radius <= RAD_W'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width       <= cfg_data;
        REG_GRID_HEIGHT: grid_height      <= cfg_data;
        REG_RADIUS:      inflation_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size and radius
  coord_t           eff_w;
  coord_t           eff_h;
  logic [RAD_W-1:0] eff_r;
  coord_t           rad_e;

  assign eff_w = (grid_width > W_CAP) ? W_CAP : grid_width;
  assign eff_h = (grid_height > H_CAP) ? H_CAP : grid_height;
  assign eff_r = (inflation_radius > R_CAP) ? R_CAP : inflation_radius;
  assign rad_e = REG_W'(eff_r);

  // Decode the incoming word
  coord_t xe, ye, x_sum, y_sum;
  coord_t x_lo_in, x_hi_in, y_lo_in, y_hi_in;
  logic   in_grid;
  logic   accept;
  logic   do_write;

  assign xe       = REG_W'(cell_x);
  assign ye       = REG_W'(cell_y);
  assign in_grid  = (xe < eff_w) && (ye < eff_h);
  assign x_sum    = xe + rad_e;
  assign y_sum    = ye + rad_e;
  assign x_lo_in  = (xe >= rad_e) ? (xe - rad_e) : '0;
  assign y_lo_in  = (ye >= rad_e) ? (ye - rad_e) : '0;
  assign x_hi_in  = (x_sum < eff_w) ? x_sum : (eff_w - REG_W'(1));
  assign y_hi_in  = (y_sum < eff_h) ? y_sum : (eff_h - REG_W'(1));
  assign accept   = in_valid && in_ready;
  assign do_write = accept && (opcode == OP_WRITE) && in_grid;

  // Scan state
  state_t state, state_next;
  coord_t sx, sy, x_lo, x_hi, y_hi, cx, cy;
  logic   rd_pend, rd_center;
  logic   hit;
  logic   res_oog;
  logic signed [CELL_W-1:0] center_val;
  logic   last_issue;
  logic   load_out;

  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] rdata;

  assign last_issue = (sx == x_hi) && (sy == y_hi);
  assign waddr = AW'(ye * MAX_WIDTH + xe);
  assign raddr = AW'(sy * MAX_WIDTH + sx);

  ogi_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (do_write),
    .waddr(waddr),
    .wdata(write_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_READ)) begin
          state_next = in_grid ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the window and walk it row by row
  always_ff @(posedge clk) begin
    if (accept) begin
      sx      <= x_lo_in;
      sy      <= y_lo_in;
      x_lo    <= x_lo_in;
      x_hi    <= x_hi_in;
      y_hi    <= y_hi_in;
      cx      <= xe;
      cy      <= ye;
      res_oog <= !in_grid;
    end else if (state == ST_SCAN) begin
      if (sx == x_hi) begin
        sx <= x_lo;
        sy <= sy + REG_W'(1);
      end else begin
        sx <= sx + REG_W'(1);
      end
    end
  end

  // Track reads in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_center <= (sx == cx) && (sy == cy);
  end

  // Fold returning cells into the obstacle flag and grab the center cell
  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= 1'b0;
      center_val <= '0;
    end else if (rd_pend) begin
      if (is_obstacle(rdata)) begin
        hit <= 1'b1;
      end
      if (rd_center) begin
        center_val <= rdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_of_grid <= res_oog;
      if (res_oog) begin
        inflated_value <= '0;
      end else if (center_val != CELL_HARD && hit) begin
        inflated_value <= CELL_MARK;
      end else begin
        inflated_value <= center_val;
      end
    end
  end

  // Checks
  a_write_idle : assert property (@(posedge clk) disable iff (rst)
    do_write |-> state == ST_IDLE)
    else $error("grid write outside idle");

  a_scan_bounds : assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (sx >= x_lo) && (sx <= x_hi) && (sy <= y_hi))
    else $error("scan position left its window");

  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");

  a_oog_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_grid |-> inflated_value == '0)
    else $error("flagged result carries a value");

endmodule

`default_nettype wire
